/* src/vrha_pkg.sv */
package vrha_pkg;

  localparam int GRID_X_DEF    = 16;
  localparam int GRID_Y_DEF    = 16;
  localparam int GRID_Z_DEF    = 16;
  localparam int MAX_STEPS_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LENGTH = 3'd0,
    REG_MARCH_LIMIT = 3'd1,
    REG_INV_VOXEL   = 3'd2,
    REG_BASE_X      = 3'd3,
    REG_BASE_Y      = 3'd4,
    REG_BASE_Z      = 3'd5,
    REG_FADE        = 3'd6,
    REG_UNUSED      = 3'd7
  } cfg_reg_t;

  localparam logic OP_RAY   = 1'b0;
  localparam logic OP_DECAY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_M_CHECK,
    ST_M_PX,
    ST_M_PY,
    ST_M_PZ,
    ST_M_IX,
    ST_M_IY,
    ST_M_IZ,
    ST_M_ADDR,
    ST_M_READ,
    ST_M_WRITE,
    ST_D_READ,
    ST_D_WAIT,
    ST_D_MUL,
    ST_D_WRITE,
    ST_DONE
  } vrha_state_t;

  // operand select for the shared multiplier
  typedef enum logic [2:0] {
    MS_HX, MS_HY, MS_HZ, MS_TU, MS_IDX, MS_FADE
  } mul_sel_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* src/vrha_ram.sv */
module vrha_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* src/vrha_sqrtdiv.sv */
module vrha_sqrtdiv
  import vrha_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // square root: one result bit per cycle
  input  logic               sqrt_go,
  input  logic [49:0]        sqrt_arg,
  // unsigned divide: one quotient bit per cycle
  input  logic               div_go,
  input  logic [37:0]        div_num,
  input  logic [25:0]        div_den,
  output logic               busy,
  output logic [37:0]        result
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic        mode_r, mode_nxt;
  logic [49:0] rem_r, rem_nxt;
  logic [49:0] work_r, work_nxt;
  logic [37:0] q_r, q_nxt;
  logic [25:0] den_r, den_nxt;
  logic [51:0] trial;
  logic [38:0] dtrial;

  always_comb begin
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    trial    = '0;
    dtrial   = '0;
    if (sqrt_go) begin
      mode_nxt = 1'b0;
      cnt_nxt  = 6'd25;
      rem_nxt  = '0;
      work_nxt = sqrt_arg;
      q_nxt    = '0;
    end else if (div_go) begin
      mode_nxt = 1'b1;
      cnt_nxt  = 6'd38;
      rem_nxt  = '0;
      work_nxt = {12'd0, div_num};
      q_nxt    = '0;
      den_nxt  = div_den;
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!mode_r) begin
        // restoring square root on two argument bits
        trial = {rem_r, work_r[49:48]} - {12'd0, q_r, 2'b01};
        work_nxt = {work_r[47:0], 2'b00};
        if (!trial[51]) begin
          rem_nxt = trial[49:0];
          q_nxt   = {q_r[36:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[47:0], work_r[49:48]};
          q_nxt   = {q_r[36:0], 1'b0};
        end
      end else begin
        // restoring division
        dtrial = {rem_r[37:0], work_r[37]} - {13'd0, den_r};
        work_nxt = {work_r[48:0], 1'b0};
        if (!dtrial[38]) begin
          rem_nxt = {12'd0, dtrial[37:0]};
          q_nxt   = {q_r[36:0], 1'b1};
        end else begin
          rem_nxt = {11'd0, rem_r[37:0], work_r[37]};
          q_nxt   = {q_r[36:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mode_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      mode_r <= mode_nxt;
    end
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    q_r    <= q_nxt;
    den_r  <= den_nxt;
  end

  assign busy   = (cnt_r != 6'd0);
  assign result = q_r;

endmodule

/* src/voxel_ray_heat_accumulator.sv */
// ray item: normalization (three squares, a square root, three divides; a zero heading ends
//   before the root), then per march step ST_M_CHECK to ST_M_READ, plus ST_M_WRITE when the sample lands in the grid
// decay item: read, wait, multiply and write for each voxel over the whole grid, then ST_DONE
// one item at a time; in_tready low while an item is in flight or a result waits
// reset (rst_n low, synchronous) restores the configuration and control registers, then a
//   clearing pass over every cell zeroes the grid before the first item is taken
module voxel_ray_heat_accumulator
  import vrha_pkg::*;
#(
  parameter int GRID_X    = GRID_X_DEF,
  parameter int GRID_Y    = GRID_Y_DEF,
  parameter int GRID_Z    = GRID_Z_DEF,
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // start_x, start_y, start_z, heading_x, heading_y, heading_z, ray_heat, pad
  input  logic [127:0]          in_tdata,
  // opcode
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // voxels_updated, step_cap_hit, pad
  output logic [15:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
  localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int KW     = $clog2(MAX_STEPS + 1);

  // configuration registers
  logic [15:0]        step_len_r;
  logic [19:0]        march_lim_r;
  logic [15:0]        inv_vox_r;
  logic signed [19:0] base_x_r, base_y_r, base_z_r;
  logic [15:0]        fade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r  <= 16'd128;
      march_lim_r <= 20'd38400;
      inv_vox_r   <= 16'd256;
      base_x_r    <= '0;
      base_y_r    <= '0;
      base_z_r    <= '0;
      fade_r      <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_LENGTH: step_len_r  <= cfg_wdata[15:0];
        REG_MARCH_LIMIT: march_lim_r <= cfg_wdata;
        REG_INV_VOXEL:   inv_vox_r   <= cfg_wdata[15:0];
        REG_BASE_X:      base_x_r    <= cfg_wdata;
        REG_BASE_Y:      base_y_r    <= cfg_wdata;
        REG_BASE_Z:      base_z_r    <= cfg_wdata;
        REG_FADE:        fade_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // item fields
  logic signed [19:0] sx_r, sy_r, sz_r;
  logic signed [15:0] hx_r, hy_r, hz_r, heat_r;
  logic signed [15:0] ux_r, uy_r, uz_r;
  logic [37:0]        len_r;
  logic [49:0]        ssum_r;
  logic [1:0]         axis_r;
  logic [20:0]        t_r;
  logic [KW-1:0]      k_r;
  logic [AW:0]        addr_r;
  logic [10:0]        count_r;
  logic               cap_r;
  logic signed [63:0] prod_r;
  logic signed [21:0] px_r, py_r, pz_r;
  logic signed [31:0] ix_r, iy_r, iz_r;
  logic               inb_r;

  vrha_state_t state_r, state_nxt;

  // shared multiplier: one signed 36x18 product per cycle, registered
  mul_sel_t           msel;
  logic signed [35:0] ma;
  logic signed [17:0] mb;
  logic signed [22:0] off;

  always_comb begin
    msel = MS_HX;
    unique case (state_r)
      ST_SQ:      msel = mul_sel_t'(axis_r);
      ST_M_PX, ST_M_PY, ST_M_PZ: msel = MS_TU;
      ST_M_IX, ST_M_IY, ST_M_IZ: msel = MS_IDX;
      default:    msel = MS_FADE;
    endcase
  end

  logic signed [15:0] u_sel;
  always_comb begin
    case (state_r)
      ST_M_PY: u_sel = uy_r;
      ST_M_PZ: u_sel = uz_r;
      default: u_sel = ux_r;
    endcase
    case (state_r)
      ST_M_IY: off = 23'(py_r) - 23'(base_y_r);
      ST_M_IZ: off = 23'(pz_r) - 23'(base_z_r);
      default: off = 23'(px_r) - 23'(base_x_r);
    endcase
  end

  logic [31:0] rd_data;

  always_comb begin
    ma = '0;
    mb = '0;
    case (msel)
      MS_HX:   begin ma = 36'(hx_r); mb = 18'(hx_r); end
      MS_HY:   begin ma = 36'(hy_r); mb = 18'(hy_r); end
      MS_HZ:   begin ma = 36'(hz_r); mb = 18'(hz_r); end
      MS_TU:   begin ma = 36'($signed({1'b0, t_r})); mb = 18'(u_sel); end
      MS_IDX:  begin ma = 36'(off); mb = $signed({2'b00, inv_vox_r}); end
      default: begin ma = 36'($signed(rd_data)); mb = $signed({2'b00, fade_r}); end
    endcase
  end

  logic signed [63:0] prod;
  assign prod = 64'(ma * mb);

  // sqrt and divide unit
  logic        sq_go, dv_go, sd_busy;
  logic [37:0] sd_res;
  logic signed [15:0] h_sel;
  logic [37:0] dnum;

  always_comb begin
    case (axis_r)
      2'd1:    h_sel = hy_r;
      2'd2:    h_sel = hz_r;
      default: h_sel = hx_r;
    endcase
    dnum = {h_sel[15] ? 16'(-32'(h_sel)) : 16'(h_sel), 22'd0};
  end

  assign sq_go = (state_r == ST_SQRT_GO);
  assign dv_go = (state_r == ST_DIV_GO);

  vrha_sqrtdiv u_sd (
    .clk      (clk),
    .rst_n    (rst_n),
    .sqrt_go  (sq_go),
    .sqrt_arg ({ssum_r[33:0], 16'd0}),
    .div_go   (dv_go),
    .div_num  (dnum),
    .div_den  (len_r[25:0]),
    .busy     (sd_busy),
    .result   (sd_res)
  );

  // grid memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  vrha_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  logic signed [63:0] scaled;
  logic signed [63:0] tr15;
  assign tr15 = prod_r[63] ? -((-prod_r) >>> 15) : (prod_r >>> 15);
  assign scaled = tr15;

  always_comb begin
    we    = 1'b0;
    waddr = addr_r[AW-1:0];
    wdata = '0;
    raddr = addr_r[AW-1:0];
    case (state_r)
      ST_CLEAR:   we = 1'b1;
      ST_M_WRITE: begin
        we = 1'b1;
        wdata = sat32(64'($signed(rd_data)) + 64'(heat_r));
      end
      ST_D_WRITE: begin
        we = 1'b1;
        wdata = sat32(scaled);
      end
      default: ;
    endcase
  end

  logic out_valid_r;
  logic in_fire, out_fire, last_cell;
  logic march_go;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign in_tready = (state_r == ST_IDLE) && !out_valid_r;
  assign last_cell = (addr_r[AW-1:0] == AW'(CELLS - 1));
  assign march_go  = ({1'b0, t_r} < {2'b00, march_lim_r}) && (32'(k_r) < MAX_STEPS);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (in_fire) state_nxt = (in_tuser == OP_DECAY) ? ST_D_READ : ST_SQ;
      ST_CLEAR:     if (last_cell) state_nxt = ST_IDLE;
      ST_SQ:        if (axis_r == 2'd2) state_nxt = ST_SQRT_GO;
      ST_SQRT_GO:   state_nxt = (ssum_r == '0) ? ST_DONE : ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (!sd_busy) state_nxt = ST_DIV_GO;
      ST_DIV_GO:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!sd_busy) state_nxt = (axis_r == 2'd2) ? ST_M_CHECK : ST_DIV_GO;
      ST_M_CHECK:   state_nxt = march_go ? ST_M_PX : ST_DONE;
      ST_M_PX:      state_nxt = ST_M_PY;
      ST_M_PY:      state_nxt = ST_M_PZ;
      ST_M_PZ:      state_nxt = ST_M_IX;
      ST_M_IX:      state_nxt = ST_M_IY;
      ST_M_IY:      state_nxt = ST_M_IZ;
      ST_M_IZ:      state_nxt = ST_M_ADDR;
      ST_M_ADDR:    state_nxt = ST_M_READ;
      ST_M_READ:    state_nxt = inb_r ? ST_M_WRITE : ST_M_CHECK;
      ST_M_WRITE:   state_nxt = ST_M_CHECK;
      ST_D_READ:    state_nxt = ST_D_WAIT;
      ST_D_WAIT:    state_nxt = ST_D_MUL;
      ST_D_MUL:     state_nxt = ST_D_WRITE;
      ST_D_WRITE:   state_nxt = last_cell ? ST_DONE : ST_D_READ;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // index conversion of the product in prod_r, truncated toward zero
  logic signed [63:0] idx_full;
  assign idx_full = prod_r[63] ? -((-prod_r) >>> 16) : (prod_r >>> 16);
  // floor shift for the t*u product
  logic signed [63:0] pofs;
  assign pofs = prod_r >>> 14;

  logic ok_x, ok_y, ok_z;
  assign ok_x = !ix_r[31] && (ix_r < 32'(GRID_X));
  assign ok_y = !iy_r[31] && (iy_r < 32'(GRID_Y));
  assign ok_z = !iz_r[31] && (iz_r < 32'(GRID_Z));

  logic signed [31:0] idx_sat;
  assign idx_sat = (idx_full > 64'sd65536) ? 32'sd65536 :
                   (idx_full < -64'sd1) ? -32'sd1 : idx_full[31:0];

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          addr_r <= '0;
          axis_r <= '0;
          if (in_fire) begin
            count_r <= '0;
            cap_r   <= 1'b0;
            ssum_r  <= '0;
            t_r     <= '0;
            k_r     <= '0;
          end
        end
        ST_CLEAR:   addr_r <= addr_r + 1'b1;
        ST_SQ:      axis_r <= axis_r + 2'd1;
        ST_SQRT_WAIT: if (!sd_busy) begin
          len_r  <= sd_res;
          axis_r <= '0;
        end
        ST_DIV_WAIT: if (!sd_busy) begin
          case (axis_r)
            2'd0:    ux_r <= hx_r[15] ? -16'(sd_res) : 16'(sd_res);
            2'd1:    uy_r <= hy_r[15] ? -16'(sd_res) : 16'(sd_res);
            default: uz_r <= hz_r[15] ? -16'(sd_res) : 16'(sd_res);
          endcase
          axis_r <= axis_r + 2'd1;
        end
        ST_M_CHECK: if (!march_go && (32'(k_r) >= MAX_STEPS)
                        && ({1'b0, t_r} < {2'b00, march_lim_r})) cap_r <= 1'b1;
        ST_M_PY:    px_r <= 22'(sx_r) + pofs[21:0];
        ST_M_PZ:    py_r <= 22'(sy_r) + pofs[21:0];
        ST_M_IX:    pz_r <= 22'(sz_r) + pofs[21:0];
        ST_M_IY:    ix_r <= idx_sat;
        ST_M_IZ:    iy_r <= idx_sat;
        ST_M_ADDR: begin
          iz_r <= idx_sat;
          t_r  <= t_r + 21'(step_len_r);
          k_r  <= k_r + 1'b1;
          // addr and bound check from indices now all settled
          inb_r  <= ok_x && ok_y && !idx_sat[31] && (idx_sat < 32'(GRID_Z));
          addr_r <= (AW+1)'((32'(ix_r) * GRID_Y + 32'(iy_r)) * GRID_Z + 32'(idx_sat));
        end
        ST_M_READ: begin
          if (inb_r && count_r != 11'd2047) count_r <= count_r + 11'd1;
        end
        ST_D_WRITE: addr_r <= addr_r + 1'b1;
        ST_DONE:    out_valid_r <= 1'b1;
        default: ;
      endcase
    end
    if (in_fire) begin
      sx_r   <= in_tdata[19:0];
      sy_r   <= in_tdata[39:20];
      sz_r   <= in_tdata[59:40];
      hx_r   <= in_tdata[75:60];
      hy_r   <= in_tdata[91:76];
      hz_r   <= in_tdata[107:92];
      heat_r <= in_tdata[123:108];
    end
    prod_r <= prod;
    if (state_r == ST_SQ) ssum_r <= ssum_r + 50'(prod);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, cap_r, count_r};

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> out_tvalid) else $error("result lost");
  a_write_inb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_M_WRITE) |-> inb_r) else $error("write outside grid");
`endif

endmodule
